### hw/rtl/spa_pkg.sv
// Shared constants, codes, types and functions of the sparse polynomial block.
// Used by spa_store, sparse_polynomial_add_multiply and its checker.
// Depends on nothing.
package spa_pkg;

  localparam int unsigned MaxTerms = 8;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned CntW     = 4;
  localparam int unsigned ExpW     = 8;
  localparam int unsigned OutExpW  = 9;
  localparam int unsigned CoefW    = 32;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned ProdW    = 64;
  localparam int unsigned FracW    = 16;
  localparam int unsigned RndW     = ProdW - FracW;
  localparam int unsigned AccW     = 56;

  localparam logic [ModeW-1:0] MODE_LOAD_A = 3'd0;
  localparam logic [ModeW-1:0] MODE_LOAD_B = 3'd1;
  localparam logic [ModeW-1:0] MODE_SUM    = 3'd2;
  localparam logic [ModeW-1:0] MODE_PROD   = 3'd3;
  localparam logic [ModeW-1:0] MODE_CLEAR  = 3'd4;

  localparam logic [StatusW-1:0] STATUS_TERM  = 2'd0;
  localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] STATUS_DONE  = 2'd2;
  localparam logic [StatusW-1:0] STATUS_FULL  = 2'd3;

  typedef struct packed {
    logic clr;
    logic ins;
  } store_ctl_t;

  function automatic logic [CoefW-1:0] sat_coef(input logic [AccW-1:0] v);
    logic [CoefW-1:0] r;
    if (v[AccW-1:CoefW-1] == {(AccW-CoefW+1){1'b0}} ||
        v[AccW-1:CoefW-1] == {(AccW-CoefW+1){1'b1}}) begin
      r = v[CoefW-1:0];
    end else if (v[AccW-1]) begin
      r = {1'b1, {(CoefW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CoefW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

### hw/rtl/spa_store.sv
// One sorted term store: insertion in exponent order, a clear, and one read port.
// Depends on spa_pkg.
module spa_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  spa_pkg::store_ctl_t           ctl_i,
  input  logic [spa_pkg::ExpW-1:0]      ins_exp_i,
  input  logic [spa_pkg::CoefW-1:0]     ins_coef_i,
  input  logic [spa_pkg::IdxW-1:0]      rd_idx_i,
  output logic [spa_pkg::ExpW-1:0]      rd_exp_o,
  output logic [spa_pkg::CoefW-1:0]     rd_coef_o,
  output logic [spa_pkg::CntW-1:0]      count_o,
  output logic                          full_o
);

  logic [spa_pkg::ExpW-1:0]  exp_q  [spa_pkg::MaxTerms];
  logic [spa_pkg::CoefW-1:0] coef_q [spa_pkg::MaxTerms];
  logic [spa_pkg::CntW-1:0]  count_q, count_d;
  logic [spa_pkg::MaxTerms-1:0] below;
  logic do_ins;

  assign full_o    = (count_q == spa_pkg::CntW'(spa_pkg::MaxTerms));
  assign do_ins    = ctl_i.ins && !full_o;
  assign count_o   = count_q;
  assign rd_exp_o  = exp_q[rd_idx_i];
  assign rd_coef_o = coef_q[rd_idx_i];

  always_comb begin
    for (int k = 0; k < spa_pkg::MaxTerms; k++) begin
      below[k] = (spa_pkg::CntW'(k) < count_q) && (exp_q[k] < ins_exp_i);
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctl_i.clr) begin
      count_d = '0;
    end else if (do_ins) begin
      count_d = count_q + spa_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_ins && !below[0]) begin
      exp_q[0]  <= ins_exp_i;
      coef_q[0] <= ins_coef_i;
    end
  end

  for (genvar k = 1; k < spa_pkg::MaxTerms; k++) begin : g_entry
    always_ff @(posedge clk_i) begin
      if (do_ins && !below[k]) begin
        if (below[k-1]) begin
          exp_q[k]  <= ins_exp_i;
          coef_q[k] <= ins_coef_i;
        end else begin
          exp_q[k]  <= exp_q[k-1];
          coef_q[k] <= coef_q[k-1];
        end
      end
    end
  end

endmodule

### hw/rtl/sparse_polynomial_add_multiply.sv
// Top level of the sparse polynomial adder and multiplier.
// Depends on spa_pkg and spa_store.
//
// The input channel carries one command word: load a term into A or B, emit
// A+B, emit A*B, or clear both lists. Each list holds up to eight terms sorted
// by exponent. Every command answers with one or more result words on the
// output channel, and the final one has last set.
// The block takes one command at a time and stalls its input until the
// answer of the previous command has been produced into its output stage.
// A sum walks both lists with one shared adder, one list position per cycle
// while the output does not stall.
// A product uses one shared 32x32 multiplier and accumulator: each pass
// steps through all a_count * b_count pairs, each pair in S_PMUL then S_PACC,
// and there is one pass per distinct result exponent plus one.
// One term is held back so that last can be set on the final word.
// On a stall the output word holds and the sequencer waits when it must push.
// Reset empties both lists and drops any word in flight.
module sparse_polynomial_add_multiply (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [spa_pkg::ModeW-1:0]       mode_i,
  input  logic [spa_pkg::ExpW-1:0]        term_exponent_i,
  input  logic signed [spa_pkg::CoefW-1:0] term_coefficient_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [spa_pkg::OutExpW-1:0]     out_exponent_o,
  output logic signed [spa_pkg::CoefW-1:0] out_coefficient_o,
  output logic                            last_o,
  output logic [spa_pkg::StatusW-1:0]     status_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_SUM   = 3'd2;
  localparam logic [2:0] S_PMUL  = 3'd3;
  localparam logic [2:0] S_PACC  = 3'd4;
  localparam logic [2:0] S_PEMIT = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  localparam int unsigned CoefW = spa_pkg::CoefW;
  localparam int unsigned AccW  = spa_pkg::AccW;
  localparam int unsigned ExpW  = spa_pkg::ExpW;
  localparam int unsigned OExpW = spa_pkg::OutExpW;
  localparam int unsigned CntW  = spa_pkg::CntW;

  logic [2:0] state_q, state_d;
  logic [spa_pkg::ModeW-1:0] mode_q, mode_d;
  logic [ExpW-1:0] exp_q, exp_d;
  logic [CoefW-1:0] coef_q, coef_d;
  logic [CntW-1:0] i_q, i_d, j_q, j_d;
  logic [OExpW-1:0] prev_q, prev_d, best_q, best_d;
  logic prev_v_q, prev_v_d, found_q, found_d, match_q, match_d;
  logic signed [spa_pkg::ProdW-1:0] prod_q, prod_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic pend_v_q, pend_v_d;
  logic [OExpW-1:0] pend_exp_q, pend_exp_d;
  logic [CoefW-1:0] pend_coef_q, pend_coef_d;
  logic out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [OExpW-1:0] out_exp_q, out_exp_d;
  logic [CoefW-1:0] out_coef_q, out_coef_d;
  logic [spa_pkg::StatusW-1:0] out_status_q, out_status_d;

  spa_pkg::store_ctl_t a_ctl, b_ctl;
  logic [ExpW-1:0] a_exp, b_exp;
  logic [CoefW-1:0] a_coef, b_coef;
  logic [CntW-1:0] a_cnt, b_cnt;
  logic a_full, b_full;

  logic in_acc, can_out, push_ok;
  logic a_v, b_v, take_eq, take_a, keep;
  logic [OExpW-1:0] t_exp, pe;
  logic [CoefW-1:0] t_coef, ssum;
  logic signed [spa_pkg::ProdW-1:0] rnd_full;
  logic [AccW-1:0] rnd_ext;

  spa_store u_store_a (
    .clk_i, .rst_ni, .ctl_i(a_ctl), .ins_exp_i(exp_q), .ins_coef_i(coef_q),
    .rd_idx_i(i_q[spa_pkg::IdxW-1:0]), .rd_exp_o(a_exp), .rd_coef_o(a_coef),
    .count_o(a_cnt), .full_o(a_full)
  );

  spa_store u_store_b (
    .clk_i, .rst_ni, .ctl_i(b_ctl), .ins_exp_i(exp_q), .ins_coef_i(coef_q),
    .rd_idx_i(j_q[spa_pkg::IdxW-1:0]), .rd_exp_o(b_exp), .rd_coef_o(b_coef),
    .count_o(b_cnt), .full_o(b_full)
  );

  assign in_stall_o        = (state_q != S_IDLE);
  assign in_acc            = in_valid_i && !in_stall_o;
  assign can_out           = !out_valid_q || !out_stall_i;
  assign push_ok           = !pend_v_q || can_out;
  assign out_valid_o       = out_valid_q;
  assign out_exponent_o    = out_exp_q;
  assign out_coefficient_o = out_coef_q;
  assign last_o            = out_last_q;
  assign status_o          = out_status_q;

  assign a_v     = (i_q < a_cnt);
  assign b_v     = (j_q < b_cnt);
  assign take_eq = a_v && b_v && (a_exp == b_exp);
  assign take_a  = !b_v || (a_v && (a_exp < b_exp));
  assign ssum    = spa_pkg::sat_coef({{(AccW-CoefW){a_coef[CoefW-1]}}, a_coef} +
                                     {{(AccW-CoefW){b_coef[CoefW-1]}}, b_coef});
  assign pe       = {1'b0, a_exp} + {1'b0, b_exp};
  assign rnd_full = prod_q + spa_pkg::ProdW'(32768);
  assign rnd_ext  = {{(AccW-spa_pkg::RndW){rnd_full[spa_pkg::ProdW-1]}},
                     rnd_full[spa_pkg::ProdW-1:spa_pkg::FracW]};

  always_comb begin
    if (take_eq) begin
      t_exp  = {1'b0, a_exp};
      t_coef = ssum;
      keep   = (ssum != '0);
    end else if (take_a) begin
      t_exp  = {1'b0, a_exp};
      t_coef = a_coef;
      keep   = 1'b1;
    end else begin
      t_exp  = {1'b0, b_exp};
      t_coef = b_coef;
      keep   = 1'b1;
    end
  end

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    exp_d        = exp_q;
    coef_d       = coef_q;
    i_d          = i_q;
    j_d          = j_q;
    prev_d       = prev_q;
    prev_v_d     = prev_v_q;
    best_d       = best_q;
    found_d      = found_q;
    match_d      = match_q;
    prod_d       = prod_q;
    acc_d        = acc_q;
    pend_v_d     = pend_v_q;
    pend_exp_d   = pend_exp_q;
    pend_coef_d  = pend_coef_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_exp_d    = out_exp_q;
    out_coef_d   = out_coef_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    a_ctl        = '0;
    b_ctl        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          mode_d   = mode_i;
          exp_d    = term_exponent_i;
          coef_d   = term_coefficient_i;
          i_d      = '0;
          j_d      = '0;
          prev_v_d = 1'b0;
          found_d  = 1'b0;
          acc_d    = '0;
          pend_v_d = 1'b0;
          if (mode_i == spa_pkg::MODE_SUM) begin
            state_d = S_SUM;
          end else if (mode_i == spa_pkg::MODE_PROD) begin
            state_d = S_PMUL;
          end else begin
            state_d = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        if (can_out) begin
          out_valid_d  = 1'b1;
          out_exp_d    = '0;
          out_coef_d   = '0;
          out_last_d   = 1'b1;
          out_status_d = spa_pkg::STATUS_DONE;
          if (mode_q == spa_pkg::MODE_LOAD_A && coef_q != '0) begin
            a_ctl.ins = 1'b1;
            if (a_full) out_status_d = spa_pkg::STATUS_FULL;
          end else if (mode_q == spa_pkg::MODE_LOAD_B && coef_q != '0) begin
            b_ctl.ins = 1'b1;
            if (b_full) out_status_d = spa_pkg::STATUS_FULL;
          end else if (mode_q == spa_pkg::MODE_CLEAR) begin
            a_ctl.clr = 1'b1;
            b_ctl.clr = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      S_SUM: begin
        if (!a_v && !b_v) begin
          state_d = S_FIN;
        end else if (!keep || push_ok) begin
          if (keep) begin
            if (pend_v_q) begin
              out_valid_d  = 1'b1;
              out_exp_d    = pend_exp_q;
              out_coef_d   = pend_coef_q;
              out_last_d   = 1'b0;
              out_status_d = spa_pkg::STATUS_TERM;
            end
            pend_v_d    = 1'b1;
            pend_exp_d  = t_exp;
            pend_coef_d = t_coef;
          end
          if (take_eq || take_a) i_d = i_q + CntW'(1);
          if (take_eq || !take_a) j_d = j_q + CntW'(1);
        end
      end
      S_PMUL: begin
        if (a_cnt == '0 || b_cnt == '0) begin
          state_d = S_FIN;
        end else begin
          if ((!prev_v_q || pe > prev_q) && (!found_q || pe < best_q)) begin
            best_d  = pe;
            found_d = 1'b1;
          end
          match_d = prev_v_q && (pe == prev_q);
          prod_d  = $signed(a_coef) * $signed(b_coef);
          state_d = S_PACC;
        end
      end
      S_PACC: begin
        if (match_q) acc_d = acc_q + rnd_ext;
        state_d = S_PMUL;
        if (j_q + CntW'(1) != b_cnt) begin
          j_d = j_q + CntW'(1);
        end else begin
          j_d = '0;
          if (i_q + CntW'(1) != a_cnt) begin
            i_d = i_q + CntW'(1);
          end else begin
            i_d     = '0;
            state_d = S_PEMIT;
          end
        end
      end
      S_PEMIT: begin
        if (!prev_v_q || push_ok) begin
          if (prev_v_q) begin
            if (pend_v_q) begin
              out_valid_d  = 1'b1;
              out_exp_d    = pend_exp_q;
              out_coef_d   = pend_coef_q;
              out_last_d   = 1'b0;
              out_status_d = spa_pkg::STATUS_TERM;
            end
            pend_v_d    = 1'b1;
            pend_exp_d  = prev_q;
            pend_coef_d = spa_pkg::sat_coef(acc_q);
          end
          if (found_q) begin
            prev_d   = best_q;
            prev_v_d = 1'b1;
            found_d  = 1'b0;
            acc_d    = '0;
            state_d  = S_PMUL;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (can_out) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          if (pend_v_q) begin
            out_exp_d    = pend_exp_q;
            out_coef_d   = pend_coef_q;
            out_status_d = spa_pkg::STATUS_TERM;
          end else begin
            out_exp_d    = '0;
            out_coef_d   = '0;
            out_status_d = spa_pkg::STATUS_EMPTY;
          end
          pend_v_d = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pend_v_q    <= 1'b0;
      prev_v_q    <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pend_v_q    <= pend_v_d;
      prev_v_q    <= prev_v_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    exp_q        <= exp_d;
    coef_q       <= coef_d;
    i_q          <= i_d;
    j_q          <= j_d;
    prev_q       <= prev_d;
    best_q       <= best_d;
    match_q      <= match_d;
    prod_q       <= prod_d;
    acc_q        <= acc_d;
    pend_exp_q   <= pend_exp_d;
    pend_coef_q  <= pend_coef_d;
    out_exp_q    <= out_exp_d;
    out_coef_q   <= out_coef_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
  end

endmodule

### hw/rtl/spa_checker.sv
// Port-level checker of sparse_polynomial_add_multiply, bound to the top level.
// Depends on spa_pkg.
module spa_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [spa_pkg::OutExpW-1:0]      out_exponent_o,
  input logic [spa_pkg::CoefW-1:0]        out_coefficient_o,
  input logic                             last_o,
  input logic [spa_pkg::StatusW-1:0]      status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_exponent_o) &&
    $stable(out_coefficient_o) && $stable(last_o) && $stable(status_o))
    else $error("Stalled output word changed.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Input not stalled while a command is in progress.");

  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == spa_pkg::STATUS_EMPTY |->
    last_o && out_exponent_o == '0 && out_coefficient_o == '0)
    else $error("Empty result word is malformed.");

  a_load_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == spa_pkg::STATUS_DONE || status_o == spa_pkg::STATUS_FULL) |->
    last_o && out_exponent_o == '0 && out_coefficient_o == '0)
    else $error("Load response word is malformed.");

endmodule

bind sparse_polynomial_add_multiply spa_checker u_spa_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .out_exponent_o, .out_coefficient_o, .last_o, .status_o
);
